>>> hw/rtl/device_slot_tracker_defines.svh
// Assertion helpers for the device slot tracker.
// Each macro expects clk and rst_n in scope.
`ifndef DEVICE_SLOT_TRACKER_DEFINES_SVH
`define DEVICE_SLOT_TRACKER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DST_ASSERT_HOLDS(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("device_slot_tracker: check failed");

// Next-cycle implication, masked during reset.
`define DST_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("device_slot_tracker: check failed");

`endif

>>> hw/rtl/dst_pkg.sv
package dst_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int SLOT_MAX       = 16;
    localparam int SLOT_IDX_MAX_W = 4;

    localparam logic [31:0]        TIMEOUT_RESET = 32'd480000;
    localparam logic signed [7:0]  RSSI_NONE     = -8'sd100;

    localparam logic [1:0] CMD_ADVERT = 2'd0;
    localparam logic [1:0] CMD_SWEEP  = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;

    localparam logic [2:0] OUTCOME_ADDR_MATCH = 3'd0;
    localparam logic [2:0] OUTCOME_ID_MATCH   = 3'd1;
    localparam logic [2:0] OUTCOME_NEW_SLOT   = 3'd2;
    localparam logic [2:0] OUTCOME_DROPPED    = 3'd3;
    localparam logic [2:0] OUTCOME_NO_ADVERT  = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        now_ms;
        logic [47:0]        link_address;
        logic [7:0]         address_type;
        logic [31:0]        device_id;
        logic [7:0]         sender_role;
        logic signed [7:0]  signal_strength;
        logic [63:0]        status_payload;
        logic [1:0]         slot_choice;
    } item_t;

    typedef struct packed {
        logic [1:0]         slot_used;
        logic [2:0]         outcome;
        logic               selected_hit;
        logic [1:0]         selected_slot;
        logic [3:0]         retired_mask;
        logic [2:0]         live_slots;
        logic               none_active;
        logic signed [7:0]  selected_rssi;
        logic [63:0]        selected_payload;
    } result_t;

    // Table update for one committed item.
    typedef struct packed {
        logic                      wr_en;
        logic [SLOT_IDX_MAX_W-1:0] wr_idx;
        logic [SLOT_MAX-1:0]       retire;
    } tbl_upd_t;

endpackage

>>> hw/rtl/dst_slot_table.sv
module dst_slot_table #(
    parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    commit,
    input  dst_pkg::tbl_upd_t       upd,
    input  dst_pkg::item_t          item,
    output logic [SLOT_COUNT-1:0]   active,
    output logic [47:0]             slot_addr [SLOT_COUNT],
    output logic [31:0]             slot_id [SLOT_COUNT],
    output logic [7:0]              slot_role [SLOT_COUNT],
    output logic signed [7:0]       slot_rssi [SLOT_COUNT],
    output logic [63:0]             slot_payload [SLOT_COUNT],
    output logic [31:0]             slot_seen [SLOT_COUNT]
);

    logic [SLOT_COUNT-1:0]  active_reg;
    logic [SLOT_COUNT-1:0]  active_next;
    logic [SLOT_COUNT-1:0]  wr_onehot;
    logic [IDX_W-1:0]       wr_idx;

    logic [47:0]            slot_addr_reg [SLOT_COUNT];
    logic [7:0]             slot_type_reg [SLOT_COUNT];
    logic [31:0]            slot_id_reg [SLOT_COUNT];
    logic [7:0]             slot_role_reg [SLOT_COUNT];
    logic signed [7:0]      slot_rssi_reg [SLOT_COUNT];
    logic [63:0]            slot_payload_reg [SLOT_COUNT];
    logic [31:0]            slot_seen_reg [SLOT_COUNT];

    assign wr_idx = upd.wr_idx[IDX_W-1:0];

    always_comb
    begin
        wr_onehot = '0;
        if (upd.wr_en)
        begin
            wr_onehot[wr_idx] = 1'b1;
        end
        active_next = (active_reg & ~upd.retire[SLOT_COUNT-1:0]) | wr_onehot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (commit)
        begin
            active_reg <= active_next;
        end
    end

    // Entry contents: no reset, only read while the slot is active.
    always_ff @(posedge clk)
    begin
        if (commit && upd.wr_en)
        begin
            slot_addr_reg[wr_idx]    <= item.link_address;
            slot_type_reg[wr_idx]    <= item.address_type;
            slot_id_reg[wr_idx]      <= item.device_id;
            slot_role_reg[wr_idx]    <= item.sender_role;
            slot_rssi_reg[wr_idx]    <= item.signal_strength;
            slot_payload_reg[wr_idx] <= item.status_payload;
            slot_seen_reg[wr_idx]    <= item.now_ms;
        end
    end

    assign active       = active_reg;
    assign slot_addr    = slot_addr_reg;
    assign slot_id      = slot_id_reg;
    assign slot_role    = slot_role_reg;
    assign slot_rssi    = slot_rssi_reg;
    assign slot_payload = slot_payload_reg;
    assign slot_seen    = slot_seen_reg;

endmodule

>>> hw/rtl/dst_step.sv
module dst_step #(
    parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  dst_pkg::item_t          item,
    input  logic [31:0]             age_limit,
    input  logic [IDX_W-1:0]        selected,
    input  logic [SLOT_COUNT-1:0]   active,
    input  logic [47:0]             slot_addr [SLOT_COUNT],
    input  logic [31:0]             slot_id [SLOT_COUNT],
    input  logic [7:0]              slot_role [SLOT_COUNT],
    input  logic signed [7:0]       slot_rssi [SLOT_COUNT],
    input  logic [63:0]             slot_payload [SLOT_COUNT],
    input  logic [31:0]             slot_seen [SLOT_COUNT],
    output dst_pkg::tbl_upd_t       upd,
    output logic [IDX_W-1:0]        selected_next,
    output dst_pkg::result_t        res
);

    logic [SLOT_COUNT-1:0]  addr_hit;
    logic [SLOT_COUNT-1:0]  id_hit;
    logic [SLOT_COUNT-1:0]  stale;
    logic [SLOT_COUNT-1:0]  expire;
    logic [SLOT_COUNT-1:0]  active_next;
    logic [IDX_W-1:0]       wr_idx;

    // Lowest set bit of a slot vector.
    function automatic logic [IDX_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Per-slot compares, all in parallel.
    always_comb
    begin
        logic [31:0] age;
        age = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            addr_hit[i] = active[i] && (slot_addr[i] == item.link_address);
            id_hit[i]   = active[i] && (slot_id[i] == item.device_id)
                          && (slot_role[i] == item.sender_role);
            age         = item.now_ms - slot_seen[i];
            stale[i]    = active[i] && (age > age_limit);
        end
    end

    always_comb
    begin
        upd           = '0;
        res           = '0;
        res.outcome   = dst_pkg::OUTCOME_NO_ADVERT;
        wr_idx        = '0;
        expire        = '0;
        active_next   = active;
        selected_next = selected;

        case (item.command)
            dst_pkg::CMD_ADVERT:
            begin
                upd.wr_en = 1'b1;
                if (|addr_hit)
                begin
                    wr_idx      = first_set(addr_hit);
                    res.outcome = dst_pkg::OUTCOME_ADDR_MATCH;
                end
                else if (|id_hit)
                begin
                    wr_idx      = first_set(id_hit);
                    res.outcome = dst_pkg::OUTCOME_ID_MATCH;
                end
                else if (|(~active))
                begin
                    wr_idx      = first_set(~active);
                    res.outcome = dst_pkg::OUTCOME_NEW_SLOT;
                end
                else
                begin
                    upd.wr_en   = 1'b0;
                    res.outcome = dst_pkg::OUTCOME_DROPPED;
                end
                if (upd.wr_en)
                begin
                    active_next[wr_idx] = 1'b1;
                    res.slot_used       = 2'(wr_idx);
                    res.selected_hit    = (wr_idx == selected);
                end
            end
            dst_pkg::CMD_SWEEP:
            begin
                if (age_limit != '0)
                begin
                    expire = stale;
                end
                active_next = active & ~expire;
                if (|expire)
                begin
                    if (active_next == '0)
                    begin
                        res.none_active = 1'b1;
                    end
                    else if (!active_next[selected])
                    begin
                        selected_next = first_set(active_next);
                    end
                end
            end
            dst_pkg::CMD_SELECT:
            begin
                if (int'(item.slot_choice) < SLOT_COUNT)
                begin
                    selected_next    = IDX_W'(item.slot_choice);
                    res.selected_hit = active[IDX_W'(item.slot_choice)];
                end
            end
            default:
            begin
            end
        endcase

        upd.wr_idx = dst_pkg::SLOT_IDX_MAX_W'(wr_idx);
        upd.retire = dst_pkg::SLOT_MAX'(expire);

        res.selected_slot = 2'(selected_next);
        res.retired_mask  = 4'(expire);
        res.live_slots    = 3'($countones(active_next));

        // Selected slot contents after this step; bypass a fresh write.
        if (active_next[selected_next])
        begin
            if (upd.wr_en && (wr_idx == selected_next))
            begin
                res.selected_rssi    = item.signal_strength;
                res.selected_payload = item.status_payload;
            end
            else
            begin
                res.selected_rssi    = slot_rssi[selected_next];
                res.selected_payload = slot_payload[selected_next];
            end
        end
        else
        begin
            res.selected_rssi    = dst_pkg::RSSI_NONE;
            res.selected_payload = '0;
        end
    end

endmodule

>>> hw/rtl/device_slot_tracker.sv
// Device slot tracker: a table of SLOT_COUNT tracked radio devices, updated by
// advert, sweep and select commands, one result per accepted command. An item
// is registered on input, decided in one pass of parallel per-slot compares
// (address, id and role, wrapping age against age_limit) and written to the
// result register once that register is free or being drained; one item per
// cycle is sustained while results are taken. The table itself lives in
// flip-flops; its entry contents have no reset and are only consulted while
// their active bit is set. age_limit is written over the cfg channel, which
// is always ready; write it only while no command is in flight. An age limit
// of zero turns the sweep into a no-op.
`include "device_slot_tracker_defines.svh"

module device_slot_tracker #(
    parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        age_limit,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [31:0]        now_ms,
    input  logic [47:0]        link_address,
    input  logic [7:0]         address_type,
    input  logic [31:0]        device_id,
    input  logic [7:0]         sender_role,
    input  logic signed [7:0]  signal_strength,
    input  logic [63:0]        status_payload,
    input  logic [1:0]         slot_choice,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         slot_used,
    output logic [2:0]         outcome,
    output logic               selected_hit,
    output logic [1:0]         selected_slot,
    output logic [3:0]         retired_mask,
    output logic [2:0]         live_slots,
    output logic               none_active,
    output logic signed [7:0]  selected_rssi,
    output logic [63:0]        selected_payload
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                   in_valid_reg;
    dst_pkg::item_t         item_reg;
    logic                   out_valid_reg;
    dst_pkg::result_t       res_reg;
    logic [IDX_W-1:0]       selected_reg;
    logic [31:0]            timeout_reg;

    logic                   advance;
    dst_pkg::tbl_upd_t      upd;
    dst_pkg::result_t       res_next;
    logic [IDX_W-1:0]       selected_next;
    logic [SLOT_COUNT-1:0]  active;

    logic [47:0]            slot_addr [SLOT_COUNT];
    logic [31:0]            slot_id [SLOT_COUNT];
    logic [7:0]             slot_role [SLOT_COUNT];
    logic signed [7:0]      slot_rssi [SLOT_COUNT];
    logic [63:0]            slot_payload [SLOT_COUNT];
    logic [31:0]            slot_seen [SLOT_COUNT];

    // Move the held item into the result register when that register is free
    // or being drained this cycle; the input stage refills in the same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            selected_reg  <= '0;
            timeout_reg   <= dst_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                selected_reg  <= selected_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                timeout_reg <= age_limit;
            end
        end
    end

    // Payload registers: hold unless a transfer moves them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command         <= command;
            item_reg.now_ms          <= now_ms;
            item_reg.link_address    <= link_address;
            item_reg.address_type    <= address_type;
            item_reg.device_id       <= device_id;
            item_reg.sender_role     <= sender_role;
            item_reg.signal_strength <= signal_strength;
            item_reg.status_payload  <= status_payload;
            item_reg.slot_choice     <= slot_choice;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    dst_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .upd          (upd),
        .item         (item_reg),
        .active       (active),
        .slot_addr    (slot_addr),
        .slot_id      (slot_id),
        .slot_role    (slot_role),
        .slot_rssi    (slot_rssi),
        .slot_payload (slot_payload),
        .slot_seen    (slot_seen)
    );

    dst_step #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_step (
        .item          (item_reg),
        .age_limit     (timeout_reg),
        .selected      (selected_reg),
        .active        (active),
        .slot_addr     (slot_addr),
        .slot_id       (slot_id),
        .slot_role     (slot_role),
        .slot_rssi     (slot_rssi),
        .slot_payload  (slot_payload),
        .slot_seen     (slot_seen),
        .upd           (upd),
        .selected_next (selected_next),
        .res           (res_next)
    );

    assign out_valid        = out_valid_reg;
    assign slot_used        = res_reg.slot_used;
    assign outcome          = res_reg.outcome;
    assign selected_hit     = res_reg.selected_hit;
    assign selected_slot    = res_reg.selected_slot;
    assign retired_mask     = res_reg.retired_mask;
    assign live_slots       = res_reg.live_slots;
    assign none_active      = res_reg.none_active;
    assign selected_rssi    = res_reg.selected_rssi;
    assign selected_payload = res_reg.selected_payload;

    // A committed advert leaves its slot active.
    `DST_ASSERT_NEXT(a_write_sets_active, advance && upd.wr_en,
        active[$past(upd.wr_idx[IDX_W-1:0])])
    // A result reporting an empty table matches the table it left behind.
    `DST_ASSERT_HOLDS(a_none_means_empty, out_valid_reg && res_reg.none_active,
        active == '0)
    // The reported count tracks the live active bits while the result is held.
    `DST_ASSERT_HOLDS(a_count_tracks, out_valid_reg,
        res_reg.live_slots == 3'($countones(active)))
    // The selection never points past the table.
    `DST_ASSERT_HOLDS(a_selected_range, 1'b1, int'(selected_reg) < SLOT_COUNT)

endmodule
